// ----- hw/rtl/mtgr_pkg.sv -----
// ----------------------------------------------------------------------------
// mtgr_pkg: shared constants and functions for the MT19937 keystream cipher
// Generator constants, twist and temper steps, byte count saturation, byte masks,
// state index wrapping and the length-dependent 2-bit rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package mtgr_pkg;

  localparam int unsigned MT_N    = 624;
  localparam int unsigned MT_M    = 397;
  localparam int unsigned IDX_W   = $clog2(MT_N);
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned ROT     = 2;

  localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C    = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET  = 32'd5489;

  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(MT_N - 1);
  localparam logic [IDX_W-1:0] IDX_WRAP_M   = IDX_W'(MT_N - MT_M);
  localparam logic [IDX_W-1:0] IDX_M        = IDX_W'(MT_M);

  // register indexes on the config port
  localparam logic REG_SEED    = 1'b0;
  localparam logic REG_DECRYPT = 1'b1;

  // byte counts
  localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
  localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
  localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (n == '0) begin
      r = CNT_ONE;
    end else if (n > CNT_FOUR) begin
      r = CNT_FOUR;
    end else begin
      r = n;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
    logic [WORD_W-1:0] m;
    case (n)
      CNT_ONE:   m = 32'h0000_00ff;
      CNT_TWO:   m = 32'h0000_ffff;
      CNT_THREE: m = 32'h00ff_ffff;
      default:   m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // next state word from mt[i], mt[i+1], mt[i+M]
  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b,
                                              input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = {a[WORD_W-1], b[WORD_W-2:0]};
    v = c ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MT_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // rotate by ROT within 8*n bits; right for encrypt, left for decrypt
  function automatic logic [WORD_W-1:0] rotate_block(input logic [WORD_W-1:0] x,
                                                     input logic [CNT_W-1:0]  n,
                                                     input logic              left);
    logic [WORD_W-1:0] r;
    case (n)
      CNT_ONE:   r = left ? {24'd0, x[5:0],  x[7:6]}   : {24'd0, x[1:0], x[7:2]};
      CNT_TWO:   r = left ? {16'd0, x[13:0], x[15:14]} : {16'd0, x[1:0], x[15:2]};
      CNT_THREE: r = left ? {8'd0,  x[21:0], x[23:22]} : {8'd0,  x[1:0], x[23:2]};
      default:   r = left ? {x[29:0], x[31:30]}        : {x[1:0], x[31:2]};
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_plus1(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_plus_m(input logic [IDX_W-1:0] i);
    return (i >= IDX_WRAP_M) ? i - IDX_WRAP_M : i + IDX_M;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mtgr_ram.sv -----
// ----------------------------------------------------------------------------
// mtgr_ram: generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mtgr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output      logic [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mt19937_gamma_rotate_cipher.sv -----
// ----------------------------------------------------------------------------
// mt19937_gamma_rotate_cipher: MT19937 keystream XOR cipher with 2-bit rotate
// XORs each 1..4 byte block with the next tempered MT19937 word and rotates
// it within its own length; the generator state lives in a 624-word RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  data     | data_valid / data_ready     | data_word, valid_bytes, restart
//  result   | result_valid / result_ready | result_word, result_bytes
//  config   | cfg_we (no wait)            | cfg_index, cfg_wdata
//
//  Accept in the idle state, two RAM read states (p and p+397, then p+1), then
//  one state that twists, tempers, writes back and loads the result; the three
//  state reads on two read ports set the read states. A new word is taken only
//  when idle. A reseed (restart, or first word after reset) first writes all
//  624 state words, one per cycle. Reset clears control and resets config.
//  A stalled result holds in the output register; the next word is still
//  taken when idle, and its last cycle waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_gamma_rotate_cipher
  import mtgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [WORD_W-1:0] cfg_wdata,
  input  wire logic              data_valid,
  output      logic              data_ready,
  input  wire logic [WORD_W-1:0] data_word,
  input  wire logic [CNT_W-1:0]  valid_bytes,
  input  wire logic              restart,
  output      logic              result_valid,
  input  wire logic              result_ready,
  output      logic [WORD_W-1:0] result_word,
  output      logic [CNT_W-1:0]  result_bytes
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEED = 5'b00010,
    ST_RD1  = 5'b00100,
    ST_RD2  = 5'b01000,
    ST_CALC = 5'b10000
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] seed;
  logic              decrypt_mode;
  logic              seeded;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  cnt;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] in_word;
  logic [CNT_W-1:0]  in_bytes;
  logic [WORD_W-1:0] word_p;
  logic [WORD_W-1:0] word_m;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  logic              accept;
  logic              calc_go;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] gamma;
  logic [WORD_W-1:0] x_in;
  logic [WORD_W-1:0] x_out;

  assign data_ready = (state == ST_IDLE);
  assign accept     = data_valid && data_ready;
  assign calc_go    = (state == ST_CALC) && (!result_valid || result_ready);

  // seeding recurrence; entry 0 is the seed itself
  assign seed_word = (cnt == '0) ? seed
                   : (SEED_MULT * (prev ^ (prev >> 30))) + {{(WORD_W-IDX_W){1'b0}}, cnt};

  assign new_word = twist(word_p, rdata_a, word_m);
  assign mask     = byte_mask(in_bytes);
  assign gamma    = temper(new_word) & mask;
  assign x_in     = in_word & mask;

  always_comb begin
    if (decrypt_mode) begin
      x_out = rotate_block(x_in, in_bytes, 1'b1) ^ gamma;
    end else begin
      x_out = rotate_block(x_in ^ gamma, in_bytes, 1'b0);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = new_word;
    raddr_a   = pos;
    raddr_b   = idx_plus_m(pos);
    case (state)
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = seed_word;
      end
      ST_RD2, ST_CALC: begin
        raddr_a = idx_plus1(pos);
        ram_we  = calc_go;
      end
      default: begin
      end
    endcase
  end

  mtgr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MT_N)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= SEED_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:    seed <= cfg_wdata;
        REG_DECRYPT: decrypt_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seeded       <= 1'b0;
      pos          <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (calc_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (restart || !seeded) begin
              state  <= ST_SEED;
              cnt    <= '0;
              seeded <= 1'b1;
            end else begin
              state <= ST_RD1;
            end
          end
        end
        ST_SEED: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_LAST) begin
            pos   <= '0;
            state <= ST_RD1;
          end
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (calc_go) begin
            pos   <= idx_plus1(pos);
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      in_word  <= data_word;
      in_bytes <= sat_count(valid_bytes);
    end
    if (state == ST_SEED) begin
      prev <= seed_word;
    end
    if (state == ST_RD2) begin
      word_p <= rdata_a;
      word_m <= rdata_b;
    end
    if (calc_go) begin
      result_word  <= x_out;
      result_bytes <= in_bytes;
    end
  end

endmodule

`default_nettype wire
